FILE: rtl/core/fbe_pkg.sv
// ----------------------------------------------------------------------------
// fbe_pkg
// Shared types and constants of the framebuffer blit engine.
// ----------------------------------------------------------------------------
package fbe_pkg;

    localparam int ADDR_W    = 32;
    localparam int POS_W     = 10;
    localparam int DIM_W     = 11;
    localparam int COLOR_W   = 16;
    localparam int MODE_W    = 2;
    localparam int OFFS_W    = 22;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_DIM_DEFAULT = 1024;
    localparam int QUEUE_DEPTH     = 4;

    // request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // draw modes, code 3 is unused
    localparam logic [MODE_W-1:0] MODE_BITMAP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COPY   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOUR = 2'd2;

    localparam logic [ADDR_W-1:0]  FRAME_BASE_RESET  = 32'h0000_0000;
    localparam logic [DIM_W-1:0]   LINE_PIXELS_RESET = 11'd480;
    localparam logic [COLOR_W-1:0] FORE_COLOUR_RESET = 16'hffff;

    // index of the last bit of a bitmap byte
    localparam logic [2:0] BIT_LAST = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]  frame_base;
        logic [DIM_W-1:0]   line_pixels;
        logic [COLOR_W-1:0] fore_colour;
    } cfg_t;

    // classified request, as queued between front and back
    typedef struct packed {
        logic               is_start;
        logic               go;        // start that arms the engine
        logic [MODE_W-1:0]  mode;
        logic [DIM_W-1:0]   width;     // already clamped
        logic [DIM_W-1:0]   height;
        logic [COLOR_W-1:0] invert;
        logic [OFFS_W-1:0]  offset;    // y * stride + x, in pixels
        logic [COLOR_W-1:0] data;
    } cmd_t;

endpackage

FILE: rtl/core/fbe_front.sv
// ----------------------------------------------------------------------------
// fbe_front
// Accepts requests, clamps sizes, checks the mode and computes the pixel
// offset of the rectangle origin. One registered stage feeds the queue.
// ----------------------------------------------------------------------------
module fbe_front #(
    parameter int MAX_DIM = fbe_pkg::MAX_DIM_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [fbe_pkg::DIM_W-1:0]   line_pixels,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [fbe_pkg::POS_W-1:0]   s_pos_x,
    input  logic [fbe_pkg::POS_W-1:0]   s_pos_y,
    input  logic [fbe_pkg::DIM_W-1:0]   s_width_px,
    input  logic [fbe_pkg::DIM_W-1:0]   s_height_px,
    input  logic [fbe_pkg::MODE_W-1:0]  s_draw_mode,
    input  logic [fbe_pkg::COLOR_W-1:0] s_invert_mask,
    input  logic [fbe_pkg::COLOR_W-1:0] s_data_word,
    output logic                        q_valid,
    input  logic                        q_ready,
    output fbe_pkg::cmd_t               q_cmd
);

    logic          stage_valid_reg, stage_valid_next;
    fbe_pkg::cmd_t stage_reg;
    fbe_pkg::cmd_t cmd_next;
    logic [fbe_pkg::DIM_W-1:0]  wid_clamp, hgt_clamp;
    logic [fbe_pkg::OFFS_W-2:0] prod;
    logic                       take;

    assign s_ready = !stage_valid_reg || q_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        wid_clamp = (32'(s_width_px) > MAX_DIM) ? fbe_pkg::DIM_W'(MAX_DIM) : s_width_px;
        hgt_clamp = (32'(s_height_px) > MAX_DIM) ? fbe_pkg::DIM_W'(MAX_DIM) : s_height_px;
        prod      = (fbe_pkg::OFFS_W-1)'(s_pos_y) * (fbe_pkg::OFFS_W-1)'(line_pixels);

        cmd_next          = '0;
        cmd_next.is_start = (s_req_type == fbe_pkg::REQ_START);
        cmd_next.mode     = s_draw_mode;
        cmd_next.width    = wid_clamp;
        cmd_next.height   = hgt_clamp;
        cmd_next.invert   = s_invert_mask;
        cmd_next.offset   = fbe_pkg::OFFS_W'(prod) + fbe_pkg::OFFS_W'(s_pos_x);
        cmd_next.data     = s_data_word;
        cmd_next.go       = (wid_clamp != '0) && (hgt_clamp != '0) &&
                            (s_draw_mode == fbe_pkg::MODE_BITMAP ||
                             s_draw_mode == fbe_pkg::MODE_FILL ||
                             s_draw_mode == fbe_pkg::MODE_COPY);

        stage_valid_next = stage_valid_reg;
        if (take) begin
            stage_valid_next = 1'b1;
        end else if (q_ready) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
        if (take) begin
            stage_reg <= cmd_next;
        end
    end

    assign q_valid = stage_valid_reg;
    assign q_cmd   = stage_reg;

endmodule

FILE: rtl/core/fbe_queue.sv
// ----------------------------------------------------------------------------
// fbe_queue
// Small request queue between front and back.
// ----------------------------------------------------------------------------
module fbe_queue #(
    parameter int DEPTH = fbe_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  fbe_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output fbe_pkg::cmd_t rd_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fbe_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: rtl/core/fbe_back.sv
// ----------------------------------------------------------------------------
// fbe_back
// Executes queued requests: holds the rectangle state and expands data
// items into pixel writes, one per unstalled cycle, via an output register.
// ----------------------------------------------------------------------------
module fbe_back #(
    parameter int MAX_DIM = fbe_pkg::MAX_DIM_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fbe_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  fbe_pkg::cmd_t               q_cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fbe_pkg::ADDR_W-1:0]  m_write_addr,
    output logic [fbe_pkg::COLOR_W-1:0] m_pixel_value,
    output logic                        m_op_last
);

    localparam int CW = $clog2(MAX_DIM + 1);

    // rectangle state
    logic                        busy_reg, busy_next;
    logic [fbe_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [fbe_pkg::ADDR_W-1:0]  row_start_reg, row_start_next;
    logic [CW-1:0]               row_reg, row_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [CW-1:0]               wid_reg, wid_next;
    logic [CW-1:0]               hgt_reg, hgt_next;
    logic [fbe_pkg::COLOR_W-1:0] inv_reg, inv_next;

    // data item in progress
    logic                        act_reg, act_next;
    logic [fbe_pkg::COLOR_W-1:0] item_reg, item_next;
    logic [2:0]                  cnt_reg, cnt_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [fbe_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [fbe_pkg::COLOR_W-1:0] pix_reg, pix_next;
    logic                        last_reg, last_next;

    logic          out_free, emit, item_done, pop, is_copy;
    logic [CW-1:0] col_inc, row_inc;
    logic          row_end, rect_end;
    logic [fbe_pkg::COLOR_W-1:0] pix_value;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = act_reg && out_free;
    assign is_copy   = (mode_reg == fbe_pkg::MODE_COPY);
    assign col_inc   = col_reg + 1'b1;
    assign row_inc   = row_reg + 1'b1;
    assign row_end   = (col_inc >= wid_reg);
    assign rect_end  = row_end && (row_inc >= hgt_reg);
    assign item_done = emit && (is_copy || row_end || cnt_reg == fbe_pkg::BIT_LAST);
    assign pop       = q_valid && (!act_reg || item_done);
    assign q_ready   = !act_reg || item_done;

    always_comb begin
        if (is_copy) begin
            pix_value = (item_reg != '0) ? (item_reg ^ inv_reg) : '0;
        end else begin
            pix_value = item_reg[7] ? cfg.fore_colour : '0;
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        mode_next      = mode_reg;
        row_start_next = row_start_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        wid_next       = wid_reg;
        hgt_next       = hgt_reg;
        inv_next       = inv_reg;
        act_next       = act_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        addr_next      = addr_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            addr_next    = row_start_reg + (fbe_pkg::ADDR_W'(col_reg) << 1);
            pix_next     = pix_value;
            last_next    = rect_end;
            col_next     = col_inc;
            item_next    = {item_reg[fbe_pkg::COLOR_W-1:8], item_reg[6:0], 1'b0};
            cnt_next     = cnt_reg + 1'b1;
            if (row_end) begin
                col_next       = '0;
                row_next       = row_inc;
                row_start_next = row_start_reg +
                                 (fbe_pkg::ADDR_W'(cfg.line_pixels) << 1);
                if (rect_end) begin
                    busy_next = 1'b0;
                end
            end
            if (item_done) begin
                act_next = 1'b0;
            end
        end

        // a request popped in the same cycle follows the pixel above
        if (pop) begin
            if (q_cmd.is_start) begin
                busy_next      = q_cmd.go;
                mode_next      = q_cmd.mode;
                wid_next       = CW'(q_cmd.width);
                hgt_next       = CW'(q_cmd.height);
                inv_next       = q_cmd.invert;
                row_next       = '0;
                col_next       = '0;
                row_start_next = cfg.frame_base +
                                 (fbe_pkg::ADDR_W'(q_cmd.offset) << 1);
            end else begin
                act_next  = busy_next;
                cnt_next  = '0;
                item_next = (mode_reg == fbe_pkg::MODE_FILL) ? 16'h00ff : q_cmd.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            act_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            mode_reg    <= fbe_pkg::MODE_BITMAP;
            row_reg     <= '0;
            col_reg     <= '0;
            wid_reg     <= '0;
            hgt_reg     <= '0;
        end else begin
            busy_reg    <= busy_next;
            act_reg     <= act_next;
            m_valid_reg <= m_valid_next;
            mode_reg    <= mode_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            wid_reg     <= wid_next;
            hgt_reg     <= hgt_next;
        end
        row_start_reg <= row_start_next;
        inv_reg       <= inv_next;
        item_reg      <= item_next;
        cnt_reg       <= cnt_next;
        addr_reg      <= addr_next;
        pix_reg       <= pix_next;
        last_reg      <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_write_addr  = addr_reg;
    assign m_pixel_value = pix_reg;
    assign m_op_last     = last_reg;

    // an item only runs inside an armed rectangle
    a_act_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        act_reg |-> busy_reg)
        else $error("data item active while engine idle");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (col_reg < wid_reg))
        else $error("column beyond rectangle width");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (row_reg < hgt_reg))
        else $error("row beyond rectangle height");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && rect_end && !(pop && q_cmd.is_start)) |=> !busy_reg)
        else $error("engine still busy after final pixel");

endmodule

FILE: rtl/core/framebuffer_blit_engine_unit.sv
// ----------------------------------------------------------------------------
// framebuffer_blit_engine_unit
// 2D blitter turning rectangle requests into RGB565 framebuffer writes.
//
//   channel   prefix  direction  content
//   request   s_      in         start (origin, size, mode, mask) or data
//   write     m_      out        byte address, pixel value, last flag
//   config    cfg_    in         register index and write data
//
// A bitmap or fill data item gives min(8, pixels left in row) writes, one
// per cycle while the write channel is not stalled, set by the pixel loop
// of the back end; colour copy gives one. Starts, and data items seen while
// idle, give no write. A request passes the front stage register and the
// queue to the back end; the four-entry queue lets requests come in while
// writes are stalled. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module framebuffer_blit_engine_unit #(
    parameter int MAX_DIM = fbe_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbe_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [fbe_pkg::POS_W-1:0]     s_pos_x,
    input  logic [fbe_pkg::POS_W-1:0]     s_pos_y,
    input  logic [fbe_pkg::DIM_W-1:0]     s_width_px,
    input  logic [fbe_pkg::DIM_W-1:0]     s_height_px,
    input  logic [fbe_pkg::MODE_W-1:0]    s_draw_mode,
    input  logic [fbe_pkg::COLOR_W-1:0]   s_invert_mask,
    input  logic [fbe_pkg::COLOR_W-1:0]   s_data_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fbe_pkg::ADDR_W-1:0]    m_write_addr,
    output logic [fbe_pkg::COLOR_W-1:0]   m_pixel_value,
    output logic                          m_op_last
);

    fbe_pkg::cfg_t cfg_reg, cfg_next;
    fbe_pkg::cmd_t fq_cmd, qb_cmd;
    logic          fq_valid, fq_ready, qb_valid, qb_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                fbe_pkg::CFG_FRAME_BASE:  cfg_next.frame_base  = cfg_data;
                fbe_pkg::CFG_LINE_PIXELS: cfg_next.line_pixels = cfg_data[fbe_pkg::DIM_W-1:0];
                fbe_pkg::CFG_FORE_COLOUR: cfg_next.fore_colour = cfg_data[fbe_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_base  <= fbe_pkg::FRAME_BASE_RESET;
            cfg_reg.line_pixels <= fbe_pkg::LINE_PIXELS_RESET;
            cfg_reg.fore_colour <= fbe_pkg::FORE_COLOUR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fbe_front #(.MAX_DIM(MAX_DIM)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .line_pixels   (cfg_reg.line_pixels),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_width_px    (s_width_px),
        .s_height_px   (s_height_px),
        .s_draw_mode   (s_draw_mode),
        .s_invert_mask (s_invert_mask),
        .s_data_word   (s_data_word),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_cmd         (fq_cmd)
    );

    fbe_queue #(.DEPTH(fbe_pkg::QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    fbe_back #(.MAX_DIM(MAX_DIM)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_cmd         (qb_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_addr  (m_write_addr),
        .m_pixel_value (m_pixel_value),
        .m_op_last     (m_op_last)
    );

endmodule

FILE: tb/framebuffer_blit_engine_unit_test.sv
// ----------------------------------------------------------------------------
// framebuffer_blit_engine_unit_test
// Self-checking bench for the blit engine. Requests go in on the s_ channel,
// framebuffer writes are checked on the m_ channel against a predictor of
// the engine state, and the registers are rewritten between phases while
// the engine is drained. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module framebuffer_blit_engine_unit_test;

    localparam int                         MAX_DIM   = fbe_pkg::MAX_DIM_DEFAULT;
    localparam logic [fbe_pkg::MODE_W-1:0] MODE_NONE = 2'd3;  // unused code, never arms
    localparam int                         DRAIN     = 32;
    localparam int                         PHASE_OPS = 22;

    typedef struct packed {
        logic                        req_type;
        logic [fbe_pkg::POS_W-1:0]   x;
        logic [fbe_pkg::POS_W-1:0]   y;
        logic [fbe_pkg::DIM_W-1:0]   w;
        logic [fbe_pkg::DIM_W-1:0]   h;
        logic [fbe_pkg::MODE_W-1:0]  mode;
        logic [fbe_pkg::COLOR_W-1:0] inv;
        logic [fbe_pkg::COLOR_W-1:0] data;
    } blit_req_t;

    typedef struct packed {
        logic [fbe_pkg::ADDR_W-1:0]  addr;
        logic [fbe_pkg::COLOR_W-1:0] pixel;
        logic                        last;
    } pix_write_t;

    // Tracks the engine state and queues the writes each request causes.
    class blit_scoreboard;
        logic [fbe_pkg::ADDR_W-1:0]  base;
        logic [fbe_pkg::DIM_W-1:0]   stride;
        logic [fbe_pkg::COLOR_W-1:0] fg;
        bit                          active;
        logic [fbe_pkg::MODE_W-1:0]  mode;
        logic [fbe_pkg::ADDR_W-1:0]  row_addr;
        logic [fbe_pkg::DIM_W-1:0]   row;
        logic [fbe_pkg::DIM_W-1:0]   col;
        logic [fbe_pkg::DIM_W-1:0]   w;
        logic [fbe_pkg::DIM_W-1:0]   h;
        logic [fbe_pkg::COLOR_W-1:0] inv;
        int                          checked;
        pix_write_t                  expected_writes[$];

        function new();
            base     = fbe_pkg::FRAME_BASE_RESET;
            stride   = fbe_pkg::LINE_PIXELS_RESET;
            fg       = fbe_pkg::FORE_COLOUR_RESET;
            active   = 0;
            mode     = fbe_pkg::MODE_BITMAP;
            row_addr = '0;
            row      = '0;
            col      = '0;
            w        = '0;
            h        = '0;
            inv      = '0;
            checked  = 0;
        endfunction

        function void set_reg(logic [fbe_pkg::CFG_IDX_W-1:0] idx,
                              logic [fbe_pkg::ADDR_W-1:0] val);
            case (idx)
                fbe_pkg::CFG_FRAME_BASE:  base   = val;
                fbe_pkg::CFG_LINE_PIXELS: stride = val[fbe_pkg::DIM_W-1:0];
                fbe_pkg::CFG_FORE_COLOUR: fg     = val[fbe_pkg::COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [fbe_pkg::DIM_W-1:0] clamp_dim(logic [fbe_pkg::DIM_W-1:0] v);
            return (v > fbe_pkg::DIM_W'(MAX_DIM)) ? fbe_pkg::DIM_W'(MAX_DIM) : v;
        endfunction

        // queue one write at the current position; returns 1 at row end
        function bit put_pixel(logic [fbe_pkg::COLOR_W-1:0] v);
            pix_write_t wr;
            bit         row_end;
            wr.addr  = row_addr + {20'd0, col, 1'b0};
            wr.pixel = v;
            wr.last  = 1'b0;
            col      = col + 1'b1;
            row_end  = (col >= w);
            if (row_end) begin
                col      = '0;
                row      = row + 1'b1;
                row_addr = row_addr + {20'd0, stride, 1'b0};
                if (row >= h) begin
                    active  = 0;
                    wr.last = 1'b1;
                end
            end
            expected_writes.push_back(wr);
            return row_end;
        endfunction

        function void note_request(blit_req_t r);
            logic [7:0] bits;
            if (r.req_type == fbe_pkg::REQ_START) begin
                w        = clamp_dim(r.w);
                h        = clamp_dim(r.h);
                inv      = r.inv;
                mode     = r.mode;
                row      = '0;
                col      = '0;
                row_addr = base + ((32'(r.y) * 32'(stride) + 32'(r.x)) << 1);
                active   = (w != 0) && (h != 0) && (r.mode != MODE_NONE);
            end else if (active) begin
                if (mode == fbe_pkg::MODE_COPY) begin
                    void'(put_pixel((r.data != 0) ? (r.data ^ inv) : '0));
                end else begin
                    bits = (mode == fbe_pkg::MODE_FILL) ? 8'hff : r.data[7:0];
                    // MSB first; a row end drops the rest of the byte
                    for (int k = 7; k >= 0; k--) begin
                        if (put_pixel(bits[k] ? fg : '0))
                            break;
                    end
                end
            end
        endfunction

        function bit check_write(logic [fbe_pkg::ADDR_W-1:0] a,
                                 logic [fbe_pkg::COLOR_W-1:0] p, logic l,
                                 output string msg);
            pix_write_t e;
            msg = "";
            if (expected_writes.size() == 0) begin
                msg = $sformatf("unexpected write addr=%08h pixel=%04h last=%0b", a, p, l);
                return 0;
            end
            e = expected_writes.pop_front();
            checked++;
            if (e.addr !== a || e.pixel !== p || e.last !== l) begin
                msg = $sformatf("write %0d: addr %08h/%08h pixel %04h/%04h last %0b/%0b",
                                checked, a, e.addr, p, e.pixel, l, e.last);
                return 0;
            end
            return 1;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [fbe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fbe_pkg::ADDR_W-1:0]    cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_req_type;
    logic [fbe_pkg::POS_W-1:0]     s_pos_x;
    logic [fbe_pkg::POS_W-1:0]     s_pos_y;
    logic [fbe_pkg::DIM_W-1:0]     s_width_px;
    logic [fbe_pkg::DIM_W-1:0]     s_height_px;
    logic [fbe_pkg::MODE_W-1:0]    s_draw_mode;
    logic [fbe_pkg::COLOR_W-1:0]   s_invert_mask;
    logic [fbe_pkg::COLOR_W-1:0]   s_data_word;
    logic                          m_valid;
    logic                          m_ready;
    logic [fbe_pkg::ADDR_W-1:0]    m_write_addr;
    logic [fbe_pkg::COLOR_W-1:0]   m_pixel_value;
    logic                          m_op_last;

    blit_scoreboard sb;
    int             error_count;
    bit             no_idle;
    string          check_msg;

    framebuffer_blit_engine_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_width_px    (s_width_px),
        .s_height_px   (s_height_px),
        .s_draw_mode   (s_draw_mode),
        .s_invert_mask (s_invert_mask),
        .s_data_word   (s_data_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_addr  (m_write_addr),
        .m_pixel_value (m_pixel_value),
        .m_op_last     (m_op_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report(string msg);
        error_count++;
        $display("MISMATCH: %s", msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_write(m_write_addr, m_pixel_value, m_op_last, check_msg))
                report(check_msg);
        end
    end

    // write side backpressure: ready stretches broken by stalls
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            int hi;
            int lo;
            hi = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
            lo = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
            m_ready <= 1'b1;
            repeat (hi) @(posedge aclk);
            m_ready <= 1'b0;
            repeat (lo) @(posedge aclk);
        end
    end

    function automatic blit_req_t start_req(logic [fbe_pkg::POS_W-1:0] x,
                                            logic [fbe_pkg::POS_W-1:0] y,
                                            logic [fbe_pkg::DIM_W-1:0] w,
                                            logic [fbe_pkg::DIM_W-1:0] h,
                                            logic [fbe_pkg::MODE_W-1:0] mode,
                                            logic [fbe_pkg::COLOR_W-1:0] inv);
        blit_req_t r;
        r.req_type = fbe_pkg::REQ_START;
        r.x        = x;
        r.y        = y;
        r.w        = w;
        r.h        = h;
        r.mode     = mode;
        r.inv      = inv;
        r.data     = 16'($urandom);
        return r;
    endfunction

    // start fields are don't-care on data requests, so randomize them
    function automatic blit_req_t data_req(logic [fbe_pkg::COLOR_W-1:0] d);
        blit_req_t r;
        r          = blit_req_t'({$urandom, $urandom, $urandom});
        r.req_type = fbe_pkg::REQ_DATA;
        r.data     = d;
        return r;
    endfunction

    task automatic send_request(blit_req_t r);
        s_valid       <= 1'b1;
        s_req_type    <= r.req_type;
        s_pos_x       <= r.x;
        s_pos_y       <= r.y;
        s_width_px    <= r.w;
        s_height_px   <= r.h;
        s_draw_mode   <= r.mode;
        s_invert_mask <= r.inv;
        s_data_word   <= r.data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
    endtask

    task automatic issue(blit_req_t r);
        int gap;
        gap = 0;
        if (!no_idle) begin
            case ($urandom_range(0, 9))
                0, 1, 2:    gap = $urandom_range(1, 3);
                3:          gap = $urandom_range(10, 40);
                default:    gap = 0;
            endcase
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        send_request(r);
    endtask

    // hold requests until every write has come out and the engine is quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [fbe_pkg::CFG_IDX_W-1:0] idx,
                             logic [fbe_pkg::ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [fbe_pkg::ADDR_W-1:0] base,
                             logic [fbe_pkg::ADDR_W-1:0] stride_word,
                             logic [fbe_pkg::COLOR_W-1:0] fg);
        settle();
        write_reg(fbe_pkg::CFG_FRAME_BASE, base);
        write_reg(fbe_pkg::CFG_LINE_PIXELS, stride_word);
        write_reg(fbe_pkg::CFG_FORE_COLOUR, {16'($urandom), fg});
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_ops();
        issue(data_req(16'hffff));                          // data while idle
        issue(start_req(10'd0, 10'd0, 11'd10, 11'd2, fbe_pkg::MODE_BITMAP, 16'h0000));
        issue(data_req(16'h00a5));
        issue(data_req(16'h00ff));                          // row ends mid-byte
        issue(data_req(16'hff3c));
        issue(data_req(16'h0080));
        issue(start_req(10'd5, 10'd5, 11'd0, 11'd5, fbe_pkg::MODE_FILL, 16'h0000));
        issue(data_req(16'h0001));
        issue(start_req(10'd5, 10'd5, 11'd5, 11'd0, fbe_pkg::MODE_FILL, 16'h0000));
        issue(start_req(10'd1, 10'd1, 11'd4, 11'd4, MODE_NONE, 16'hffff));
        issue(data_req(16'h00ff));
        issue(start_req(10'h3ff, 10'h3ff, 11'd3, 11'd2, fbe_pkg::MODE_FILL, 16'h5a5a));
        issue(data_req(16'h0000));                          // fill ignores data
        issue(data_req(16'h1234));
        issue(start_req(10'd7, 10'd3, 11'd2, 11'd2, fbe_pkg::MODE_COPY, 16'hffff));
        issue(data_req(16'h0000));
        issue(data_req(16'hffff));
        issue(data_req(16'h8001));
        issue(data_req(16'h0001));
        issue(start_req(10'd0, 10'd0, 11'd2047, 11'd2047, fbe_pkg::MODE_BITMAP, 16'h0000));
        issue(data_req(16'h00ff));
        issue(data_req(16'h0055));
        // drops the busy op
        issue(start_req(10'd2, 10'd9, 11'd1, 11'd1, fbe_pkg::MODE_COPY, 16'h1234));
        issue(data_req(16'habcd));
    endtask

    function automatic logic [fbe_pkg::DIM_W-1:0] pick_dim(int short_max);
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return fbe_pkg::DIM_W'($urandom);
            default: return fbe_pkg::DIM_W'($urandom_range(1, short_max));
        endcase
    endfunction

    task automatic random_ops(int target);
        int                         done;
        int                         need;
        int                         wc;
        int                         hc;
        logic [fbe_pkg::DIM_W-1:0]  w;
        logic [fbe_pkg::DIM_W-1:0]  h;
        logic [fbe_pkg::MODE_W-1:0] mode;
        bit                         armed;
        done = 0;
        while (done < target) begin
            if ($urandom_range(0, 24) == 0)
                settle();
            if ($urandom_range(0, 11) == 0) begin
                issue(data_req(16'($urandom)));             // stray data
                continue;
            end
            mode = ($urandom_range(0, 24) == 0) ? MODE_NONE
                                                : fbe_pkg::MODE_W'($urandom_range(0, 2));
            w    = pick_dim(40);
            h    = pick_dim(6);
            no_idle = ($urandom_range(0, 3) == 0);
            issue(start_req(fbe_pkg::POS_W'($urandom), fbe_pkg::POS_W'($urandom), w, h,
                            mode, 16'($urandom)));
            done++;
            wc    = int'(sb.clamp_dim(w));
            hc    = int'(sb.clamp_dim(h));
            armed = (wc != 0) && (hc != 0) && (mode != MODE_NONE);
            if (!armed)
                need = $urandom_range(0, 2);
            else if (mode == fbe_pkg::MODE_COPY)
                need = wc * hc;
            else
                need = hc * ((wc + 7) / 8);
            // big rectangles and some others get cut short by the next start
            if (armed && (need > 40 || $urandom_range(0, 6) == 0))
                need = $urandom_range(0, (need > 20) ? 20 : need);
            repeat (need) issue(data_req(16'($urandom)));
            if (armed)
                done += need;
            no_idle = 0;
        end
    endtask

    initial begin
        sb            = new();
        error_count   = 0;
        no_idle       = 0;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_req_type    = fbe_pkg::REQ_START;
        s_pos_x       = '0;
        s_pos_y       = '0;
        s_width_px    = '0;
        s_height_px   = '0;
        s_draw_mode   = fbe_pkg::MODE_BITMAP;
        s_invert_mask = '0;
        s_data_word   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values first
        directed_ops();
        random_ops(PHASE_OPS / 2);

        configure(32'hffff_fff0, 32'hffff_ffff, 16'h0000);  // stride masks to 2047
        issue(start_req(10'h3ff, 10'h3ff, 11'd9, 11'd2, fbe_pkg::MODE_BITMAP, 16'h0000));
        repeat (4) issue(data_req(16'hffff));
        random_ops(PHASE_OPS);

        configure($urandom, 32'h0000_0000, 16'($urandom));  // zero stride
        random_ops(PHASE_OPS);

        configure(32'h0000_0000, 32'h0000_0001, 16'hffff);
        random_ops(PHASE_OPS);

        configure($urandom, 32'd1024, 16'($urandom));
        random_ops(PHASE_OPS);

        configure($urandom, {21'($urandom), 11'd0} | 32'($urandom_range(1, 1024)),
                  16'($urandom));
        random_ops(PHASE_OPS);

        configure(32'hffff_ffff, 32'd480, 16'h8000);
        random_ops(PHASE_OPS);

        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
